@@ rtl/core/point_to_depth_image_projector_macros.svh @@
// Assertion macros for the point to depth image projector checker.
`ifndef POINT_TO_DEPTH_IMAGE_PROJECTOR_MACROS_SVH
`define POINT_TO_DEPTH_IMAGE_PROJECTOR_MACROS_SVH

// Checked only while out of reset.
`define PTDIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PTDIP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ptdip_pkg.sv @@
// Shared constants, register codes and divider interface types for the projector.
package ptdip_pkg;

  localparam int IMAGE_WIDTH  = 512;
  localparam int IMAGE_HEIGHT = 512;

  localparam int PIX_COUNT = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W    = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
  localparam int MAX_DIM   = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  // 2**QUOT_W exceeds every valid coordinate
  localparam int QUOT_W    = $clog2(MAX_DIM + 1);

  localparam int POINT_W   = 26;
  localparam int POS_W     = POINT_W - 1;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam int PROD_W    = POINT_W + CFG_W + 1;
  localparam int CZ_W      = CFG_W + POS_W;
  localparam int NUM_W     = 44;
  localparam int DEN_W     = POS_W + 5;
  localparam int REM_W     = DEN_W + QUOT_W;
  localparam int DEPTH_W   = 16;
  localparam int PIX_W     = 9;

  localparam logic [31:0]       IMG_W_U = 32'(IMAGE_WIDTH);
  localparam logic [31:0]       IMG_H_U = 32'(IMAGE_HEIGHT);
  localparam logic [QUOT_W-1:0] IMG_W_Q = QUOT_W'(IMAGE_WIDTH);
  localparam logic [QUOT_W-1:0] IMG_H_Q = QUOT_W'(IMAGE_HEIGHT);

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(3);

  localparam logic ACT_PROJECT = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              over;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/core/ptdip_ram.sv @@
// Simple dual-port synchronous RAM, registered read.
module ptdip_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/ptdip_div.sv @@
// Range-checked restoring divider, one quotient bit per cycle.
module ptdip_div import ptdip_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic              busy_r;
  logic              done_r;
  logic              over_r;
  logic [REM_W-1:0]  rem_r;
  logic [REM_W-1:0]  dsr_r;
  logic [QUOT_W-1:0] quot_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [NUM_W-1:0] lim;
  logic             too_big;
  logic             ge;
  logic [REM_W-1:0] rem_sub;

  always_comb begin
    lim     = NUM_W'(req.denom) << QUOT_W;
    too_big = req.numer >= lim;
    ge      = rem_r >= dsr_r;
    rem_sub = rem_r - dsr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      over_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= (req.start && too_big) ||
                (!req.start && busy_r && (cnt_r == CNT_W'(1)));
      if (req.start) begin
        over_r <= too_big;
        quot_r <= '0;
        if (too_big) begin
          busy_r <= 1'b0;
        end else begin
          busy_r <= 1'b1;
          rem_r  <= req.numer[REM_W-1:0];
          dsr_r  <= REM_W'(req.denom) << (QUOT_W - 1);
          cnt_r  <= CNT_W'(QUOT_W);
        end
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= rem_sub;
        end
        quot_r <= (quot_r << 1) | QUOT_W'(ge);
        dsr_r  <= dsr_r >> 1;
        cnt_r  <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.over = over_r;
  assign rsp.quot = quot_r;

endmodule

@@ rtl/core/point_to_depth_image_projector.sv @@
// Point to depth image projector: sequencer, arithmetic and depth store.
//
// Input beats carry an action bit and a point or a pixel address. A project
// beat (action 0) with positive Z is projected with the pinhole model set by
// the four 16-bit registers and, when it lands inside the image, its rounded
// depth is written to the depth store. A read beat (action 1) returns the
// stored depth of one pixel and clears it. Each input beat gives exactly one
// result beat, in order.
// One item is handled at a time. A project beat runs the shared divider,
// which yields one quotient bit a cycle, for column then row; it ends
// sooner when a coordinate overflows or Z <= 0. A read beat does a
// read-then-clear of the single memory.
// The result beat is offered in the cycle in which in_stall falls again.
// After reset a clearing pass writes zero to every pixel, one per cycle;
// in_stall stays high meanwhile and register writes are still taken.
// cfg_ready is always high.
// The result is held in an output register; while out_stall is high it holds
// and the block may accept one more beat, finishing it before waiting.
module point_to_depth_image_projector import ptdip_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic signed [POINT_W-1:0] in_point_x,
  input  logic signed [POINT_W-1:0] in_point_y,
  input  logic signed [POINT_W-1:0] in_point_z,
  input  logic [PIX_W-1:0]          in_read_col,
  input  logic [PIX_W-1:0]          in_read_row,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_kept,
  output logic                      out_on_image,
  output logic [PIX_W-1:0]          out_pixel_col,
  output logic [PIX_W-1:0]          out_pixel_row,
  output logic [DEPTH_W-1:0]        out_depth_mm,
  output logic [DEPTH_W-1:0]        out_read_depth,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_SUM, S_ABS, S_START, S_WAIT, S_WRITE, S_RD, S_RDW, S_DONE
  } state_t;

  state_t state_r;

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [CFG_W-1:0]  fx_r, fy_r, cx_r, cy_r;

  logic                      act_r;
  logic signed [POINT_W-1:0] px_r, py_r, pz_r;
  logic [PIX_W-1:0]          rc_r, rr_r;
  logic                      sel_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [CZ_W-1:0]           cz_r;
  logic [NUM_W-1:0]          num_r;
  logic                      neg_r;
  logic [NUM_W-1:0]          mag_r;
  logic                      col_ok_r, row_ok_r;
  logic [QUOT_W-1:0]         col_r, row_r;
  logic [DEPTH_W-1:0]        depth_r;
  logic                      rd_inb_r;
  logic [ADDR_W-1:0]         addr_r;

  logic                 res_kept_r;
  logic                 res_on_r;
  logic [PIX_W-1:0]     res_col_r, res_row_r;
  logic [DEPTH_W-1:0]   res_depth_r;
  logic [DEPTH_W-1:0]   res_rdepth_r;

  logic                 out_valid_r;
  logic                 out_kept_r, out_on_r;
  logic [PIX_W-1:0]     out_col_r, out_row_r;
  logic [DEPTH_W-1:0]   out_depth_r, out_rdepth_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [DEPTH_W-1:0]        mem_wdata;
  logic                      mem_re;
  logic [DEPTH_W-1:0]        mem_rdata;

  logic                      in_acc;
  logic                      out_free;
  logic signed [POINT_W-1:0] coord;
  logic signed [CFG_W:0]     foc_s;
  logic [CFG_W-1:0]          cen;
  logic [POINT_W-1:0]        dsum;
  logic [POINT_W-9:0]        dshift;
  logic                      coord_ok;
  logic [31:0]               pix_lin, rd_lin, col32, row32;
  logic                      rd_inb;
  logic                      pix_on;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    coord    = sel_r ? py_r : px_r;
    foc_s    = {1'b0, (sel_r ? fy_r : fx_r)};
    cen      = sel_r ? cy_r : cx_r;
    dsum     = {1'b0, pz_r[POS_W-1:0]} + POINT_W'(128);
    dshift   = dsum[POINT_W-1:8];
    coord_ok = !div_rsp.over && ((div_rsp.quot == '0) ||
               (!neg_r && (div_rsp.quot < (sel_r ? IMG_H_Q : IMG_W_Q))));
    pix_lin  = 32'(row_r) * IMG_W_U + 32'(col_r);
    rd_lin   = 32'(rr_r) * IMG_W_U + 32'(rc_r);
    col32    = 32'(col_r);
    row32    = 32'(row_r);
    rd_inb   = (32'(rc_r) < IMG_W_U) && (32'(rr_r) < IMG_H_U);
    pix_on   = col_ok_r && row_ok_r;

    div_req.start = (state_r == S_START);
    div_req.numer = (mag_r << 1) + (NUM_W'(pz_r[POS_W-1:0]) << 4);
    div_req.denom = DEN_W'(pz_r[POS_W-1:0]) << 5;

    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
      end
      S_WRITE: begin
        mem_we    = pix_on;
        mem_waddr = pix_lin[ADDR_W-1:0];
        mem_wdata = depth_r;
      end
      S_RDW: begin
        mem_we    = rd_inb_r;
      end
      default: begin
      end
    endcase
    mem_re = (state_r == S_RD) && rd_inb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r <= '0;
      fy_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FOCAL_X:  fx_r <= cfg_data;
        REG_FOCAL_Y:  fy_r <= cfg_data;
        REG_CENTER_X: cx_r <= cfg_data;
        REG_CENTER_Y: cy_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
          if (clr_cnt_r == ADDR_W'(PIX_COUNT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            act_r        <= in_action;
            px_r         <= in_point_x;
            py_r         <= in_point_y;
            pz_r         <= in_point_z;
            rc_r         <= in_read_col;
            rr_r         <= in_read_row;
            sel_r        <= 1'b0;
            res_on_r     <= 1'b0;
            res_col_r    <= '0;
            res_row_r    <= '0;
            res_depth_r  <= '0;
            res_rdepth_r <= '0;
            if (in_action == ACT_READ) begin
              res_kept_r <= 1'b0;
              state_r    <= S_RD;
            end else if (in_point_z[POINT_W-1] || (in_point_z == '0)) begin
              res_kept_r <= 1'b0;
              state_r    <= S_DONE;
            end else begin
              res_kept_r <= 1'b1;
              state_r    <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= coord * foc_s;
          cz_r    <= cen * pz_r[POS_W-1:0];
          depth_r <= (|dshift[POINT_W-9:DEPTH_W]) ? '1 : dshift[DEPTH_W-1:0];
          state_r <= S_SUM;
        end
        S_SUM: begin
          num_r   <= {{(NUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r} +
                     {{(NUM_W-CZ_W){1'b0}}, cz_r};
          state_r <= S_ABS;
        end
        S_ABS: begin
          neg_r   <= num_r[NUM_W-1];
          mag_r   <= num_r[NUM_W-1] ? (~num_r + NUM_W'(1)) : num_r;
          state_r <= S_START;
        end
        S_START: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            if (!sel_r) begin
              col_ok_r <= coord_ok;
              col_r    <= div_rsp.quot;
              sel_r    <= 1'b1;
              state_r  <= S_MUL;
            end else begin
              row_ok_r <= coord_ok;
              row_r    <= div_rsp.quot;
              state_r  <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          res_on_r <= pix_on;
          if (pix_on) begin
            res_col_r   <= col32[PIX_W-1:0];
            res_row_r   <= row32[PIX_W-1:0];
            res_depth_r <= depth_r;
          end
          state_r <= S_DONE;
        end
        S_RD: begin
          rd_inb_r <= rd_inb;
          addr_r   <= rd_lin[ADDR_W-1:0];
          state_r  <= S_RDW;
        end
        S_RDW: begin
          res_rdepth_r <= rd_inb_r ? mem_rdata : '0;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_kept_r   <= res_kept_r;
            out_on_r     <= res_on_r;
            out_col_r    <= res_col_r;
            out_row_r    <= res_row_r;
            out_depth_r  <= res_depth_r;
            out_rdepth_r <= (act_r == ACT_READ) ? res_rdepth_r : '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  ptdip_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ptdip_ram #(
    .DEPTH (PIX_COUNT),
    .WIDTH (DEPTH_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (rd_lin[ADDR_W-1:0]),
    .rd_data (mem_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_kept       = out_kept_r;
  assign out_on_image   = out_on_r;
  assign out_pixel_col  = out_col_r;
  assign out_pixel_row  = out_row_r;
  assign out_depth_mm   = out_depth_r;
  assign out_read_depth = out_rdepth_r;

endmodule

@@ rtl/core/ptdip_chk.sv @@
// Port-level checker for the projector, bound to the top level.
`include "point_to_depth_image_projector_macros.svh"

module ptdip_chk import ptdip_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_kept,
  input logic                      out_on_image,
  input logic [PIX_W-1:0]          out_pixel_col,
  input logic [PIX_W-1:0]          out_pixel_row,
  input logic [DEPTH_W-1:0]        out_depth_mm,
  input logic [DEPTH_W-1:0]        out_read_depth
);

  // reset starts the clearing pass with no result pending
  `PTDIP_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> in_stall && !out_valid, "no clear after reset")

  `PTDIP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_depth_mm) && $stable(out_read_depth) && $stable(out_pixel_col), "stalled beat changed")

  `PTDIP_ASSERT(a_on_kept, out_valid && out_on_image |-> out_kept, "on image but not kept")

  `PTDIP_ASSERT(a_off_zero, out_valid && !out_on_image |-> out_pixel_col == '0 && out_pixel_row == '0 && out_depth_mm == '0, "off-image fields not zero")

  `PTDIP_ASSERT(a_read_excl, out_valid && out_read_depth != '0 |-> !out_kept && !out_on_image, "read beat with point flags")

endmodule

bind point_to_depth_image_projector ptdip_chk u_chk (.*);
